[rtl/tbpe_pkg.sv]
// shared types and constants of the tape bit pulse encoder
package tbpe_pkg;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_HIGH_LEVEL    = 3'd0;
  localparam reg_idx_t REG_LOW_LEVEL     = 3'd1;
  localparam reg_idx_t REG_SHORT_RUN     = 3'd2;
  localparam reg_idx_t REG_LONG_RUN      = 3'd3;
  localparam reg_idx_t REG_CHECKSUM_SEED = 3'd4;

  localparam logic [7:0] HIGH_LEVEL_RST    = 8'hff;
  localparam logic [7:0] LOW_LEVEL_RST     = 8'h00;
  localparam logic [7:0] SHORT_RUN_RST     = 8'd13;
  localparam logic [7:0] LONG_RUN_RST      = 8'd21;
  localparam logic [7:0] CHECKSUM_SEED_RST = 8'h00;

  localparam int RUNS_PER_BYTE = 32;
  localparam int RUN_IDX_W     = $clog2(RUNS_PER_BYTE);

  typedef logic [RUN_IDX_W-1:0] run_idx_t;

  localparam run_idx_t LAST_RUN_IDX = run_idx_t'(RUNS_PER_BYTE - 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] checksum;
  } job_t;

  typedef struct packed {
    logic [7:0] high_level;
    logic [7:0] low_level;
    logic [7:0] short_run;
    logic [7:0] long_run;
    logic [7:0] checksum_seed;
  } cfg_t;

  typedef struct packed {
    logic     busy;
    run_idx_t run_idx;
  } back_stat_t;

endpackage

[rtl/tbpe_if.sv]
// channel interfaces of the tape bit pulse encoder

interface tbpe_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart_sum;

  modport source (output valid, output data_byte, output restart_sum, input ready);
  modport sink   (input valid, input data_byte, input restart_sum, output ready);
endinterface

interface tbpe_run_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic [7:0] run_length;
  logic       last_run;
  logic [7:0] raw_byte;
  logic [7:0] checksum;

  modport source (
    output valid, output level, output run_length, output last_run,
    output raw_byte, output checksum, input ready
  );
  modport sink (
    input valid, input level, input run_length, input last_run,
    input raw_byte, input checksum, output ready
  );
endinterface

interface tbpe_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/tbpe_front.sv]
// front end: takes byte beats and keeps the running checksum
module tbpe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  tbpe_item_if.sink          item_i,
  input  logic [7:0]         seed_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output tbpe_pkg::job_t     push_job_o
);
  import tbpe_pkg::*;

  logic [7:0] sum_q, sum_d;
  logic [7:0] base;
  logic       accept;

  assign accept       = item_i.valid && push_ready_i;
  assign base         = item_i.restart_sum ? seed_i : sum_q;
  assign sum_d        = base + item_i.data_byte;

  assign item_i.ready = push_ready_i;
  assign push_valid_o = item_i.valid;
  assign push_job_o   = '{data_byte: item_i.data_byte, checksum: sum_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (accept) begin
      sum_q <= sum_d;
    end
  end

endmodule

[rtl/tbpe_job_queue.sv]
// short queue of encoded byte jobs between front and back
module tbpe_job_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tbpe_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output tbpe_pkg::job_t pop_job_o
);
  import tbpe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_FULL);
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/tbpe_back.sv]
// back end: steps through the 32 runs of each byte into an output register
module tbpe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tbpe_pkg::cfg_t       cfg_i,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  tbpe_pkg::job_t       pop_job_i,
  tbpe_run_if.source           run_o,
  output tbpe_pkg::back_stat_t stat_o
);
  import tbpe_pkg::*;

  job_t       job_q;
  logic       busy_q;
  run_idx_t   idx_q;
  logic       out_valid_q;
  logic [7:0] level_q, run_length_q, raw_byte_q, checksum_q;
  logic       last_run_q;

  logic       advance, last, bit_val, is_long, is_high, load;

  assign advance = busy_q && (!out_valid_q || run_o.ready);
  assign last    = (idx_q == LAST_RUN_IDX);
  assign load    = !busy_q || (advance && last);
  assign bit_val = job_q.data_byte[~idx_q[RUN_IDX_W-1:2]];
  assign is_long = bit_val ^ idx_q[1];
  assign is_high = !idx_q[0];

  assign pop_ready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= pop_valid_i;
      idx_q  <= '0;
    end else if (advance) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && pop_valid_i) begin
      job_q <= pop_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (run_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      level_q      <= is_high ? cfg_i.high_level : cfg_i.low_level;
      run_length_q <= is_long ? cfg_i.long_run : cfg_i.short_run;
      last_run_q   <= last;
      raw_byte_q   <= job_q.data_byte;
      checksum_q   <= job_q.checksum;
    end
  end

  assign run_o.valid      = out_valid_q;
  assign run_o.level      = level_q;
  assign run_o.run_length = run_length_q;
  assign run_o.last_run   = last_run_q;
  assign run_o.raw_byte   = raw_byte_q;
  assign run_o.checksum   = checksum_q;

  assign stat_o = '{busy: busy_q, run_idx: idx_q};

endmodule

[rtl/tape_bit_pulse_encoder_unit.sv]
// top level of the tape bit pulse encoder
// Each accepted byte becomes 32 run beats, four per bit, most significant bit first,
// each carrying level, run length, last-run flag, the byte and the running checksum.
// The run sequencer issues one run per cycle whenever the output channel takes it, so a
// stream of bytes is sent back to back, the next byte loading as the last run of one goes out.
// The checksum front accepts a byte and parks it in a queue of QUEUE_DEPTH
// bytes, so new bytes are taken while earlier ones are still being sent out. The first
// run of a byte passes through the queue, the sequencer's job register and the output register.
// Configuration writes are always ready; each is registered and applies to runs issued after it.
module tape_bit_pulse_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbpe_item_if.sink  item_i,
  tbpe_run_if.source run_o,
  tbpe_cfg_if.sink   cfg_i
);
  import tbpe_pkg::*;

  cfg_t       cfg_q;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  job_t       push_job, pop_job;
  back_stat_t stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{high_level:    HIGH_LEVEL_RST,
                 low_level:     LOW_LEVEL_RST,
                 short_run:     SHORT_RUN_RST,
                 long_run:      LONG_RUN_RST,
                 checksum_seed: CHECKSUM_SEED_RST};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_HIGH_LEVEL:    cfg_q.high_level    <= cfg_i.data;
        REG_LOW_LEVEL:     cfg_q.low_level     <= cfg_i.data;
        REG_SHORT_RUN:     cfg_q.short_run     <= cfg_i.data;
        REG_LONG_RUN:      cfg_q.long_run      <= cfg_i.data;
        REG_CHECKSUM_SEED: cfg_q.checksum_seed <= cfg_i.data;
        default: ;
      endcase
    end
  end

  tbpe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .seed_i       (cfg_q.checksum_seed),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  tbpe_job_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  tbpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .run_o       (run_o),
    .stat_o      (stat)
  );

  // an accepted byte sits in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> pop_valid)
    else $error("accepted byte missing from queue");

  // a waiting job is picked up as soon as the sequencer is free
  a_idle_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && !stat.busy) |=> stat.busy)
    else $error("sequencer idle with a job queued");

  // every byte starts at its first run
  a_fresh_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stat.busy) |-> (stat.run_idx == '0))
    else $error("byte started mid sequence");

endmodule

[test/tape_bit_pulse_encoder_unit_test.sv]
// testbench of the tape bit pulse encoder: directed bytes, then randomised phases against a predictor
`timescale 1ns / 1ps

module tape_bit_pulse_encoder_unit_test;
  import tbpe_pkg::*;

  localparam int RUNS_PER_BIT    = 4;
  localparam int SETTLE_CYCLES   = 6;
  localparam int IDLE_LIMIT      = 2000;
  localparam int RANDOM_PHASES   = 10;
  localparam int BYTES_PER_PHASE = 38;
  localparam int DIRECTED_ROWS   = 12;

  localparam reg_idx_t REG_UNUSED_FIRST = reg_idx_t'(REG_CHECKSUM_SEED + 1);
  localparam reg_idx_t REG_UNUSED_LAST  = '1;

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] run_length;
    logic       last_run;
    logic [7:0] raw_byte;
    logic [7:0] checksum;
  } run_beat_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart_sum;
    logic       sum_known;
    logic [7:0] checksum;
  } byte_row_t;

  logic clk;
  logic rst_n;

  tbpe_item_if item_ch();
  tbpe_run_if  run_ch();
  tbpe_cfg_if  cfg_ch();

  cfg_t       run_cfg;
  logic [7:0] running_sum;
  run_beat_t  pending_runs[$];
  run_beat_t  want;
  byte_row_t  directed_rows [DIRECTED_ROWS];
  bit         steady_flow;
  int         mismatches;
  int         bytes_sent;
  int         restarts_sent;
  int         runs_checked;
  int         zero_runs;
  int         reg_writes;
  int         unused_writes;
  int         idle_cycles;
  int         stall_left;

  tape_bit_pulse_encoder_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .item_i (item_ch),
    .run_o  (run_ch),
    .cfg_i  (cfg_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [7:0] random_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 8'h00;
    end
    if (r == 1) begin
      return 8'hff;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void apply_reg(input reg_idx_t idx, input logic [7:0] value);
    case (idx)
      REG_HIGH_LEVEL:    run_cfg.high_level    = value;
      REG_LOW_LEVEL:     run_cfg.low_level     = value;
      REG_SHORT_RUN:     run_cfg.short_run     = value;
      REG_LONG_RUN:      run_cfg.long_run      = value;
      REG_CHECKSUM_SEED: run_cfg.checksum_seed = value;
      default: begin
      end
    endcase
  endfunction

  // 32 runs per byte, msb first; a 1 bit starts with the long pair
  function automatic void queue_runs(input logic [7:0] data);
    run_beat_t beat;
    logic      one;
    int        phase;
    int        k;
    for (k = 0; k < RUNS_PER_BYTE; k++) begin
      phase           = k % RUNS_PER_BIT;
      one             = data[7 - k / RUNS_PER_BIT];
      beat.level      = (phase % 2 == 0) ? run_cfg.high_level : run_cfg.low_level;
      beat.run_length = ((phase < 2) == one) ? run_cfg.long_run : run_cfg.short_run;
      beat.last_run   = (k == RUNS_PER_BYTE - 1);
      beat.raw_byte   = data;
      beat.checksum   = running_sum;
      pending_runs.push_back(beat);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, exp_val);
    mismatches++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cfg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, value);
    reg_writes++;
    if (idx > REG_CHECKSUM_SEED) begin
      unused_writes++;
    end
  endtask

  task automatic set_config(input logic [7:0] high, input logic [7:0] low,
                            input logic [7:0] short_len, input logic [7:0] long_len,
                            input logic [7:0] seed);
    write_reg(reg_idx_t'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
              8'($urandom_range(0, 255)));
    write_reg(REG_HIGH_LEVEL, high);
    write_reg(REG_LOW_LEVEL, low);
    write_reg(REG_SHORT_RUN, short_len);
    write_reg(REG_LONG_RUN, long_len);
    write_reg(REG_CHECKSUM_SEED, seed);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_byte(input byte_row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.data_byte   <= row.data_byte;
    item_ch.restart_sum <= row.restart_sum;
    do @(posedge clk); while (!item_ch.ready);
    if (row.sum_known) begin
      running_sum = row.checksum;
    end else begin
      if (row.restart_sum) begin
        running_sum = run_cfg.checksum_seed;
      end
      running_sum = running_sum + row.data_byte;
    end
    queue_runs(row.data_byte);
    bytes_sent++;
    if (row.restart_sum) begin
      restarts_sent++;
    end
  endtask

  task automatic drain_runs();
    item_ch.valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int count);
    byte_row_t row;
    int        i;
    for (i = 0; i < count; i++) begin
      row.data_byte   = random_byte();
      row.restart_sum = ($urandom_range(0, 3) == 0);
      row.sum_known   = 1'b0;
      row.checksum    = 8'h00;
      send_byte(row);
    end
    drain_runs();
  endtask

  // run beat checker
  always @(posedge clk) begin
    if (rst_n && run_ch.valid && run_ch.ready) begin
      if (pending_runs.size() == 0) begin
        report_mismatch("unexpected run beat, level", run_ch.level, 0);
      end else begin
        want = pending_runs.pop_front();
        runs_checked++;
        if (run_ch.run_length == 8'd0) begin
          zero_runs++;
        end
        if (run_ch.level !== want.level) begin
          report_mismatch("level", run_ch.level, want.level);
        end
        if (run_ch.run_length !== want.run_length) begin
          report_mismatch("run_length", run_ch.run_length, want.run_length);
        end
        if (run_ch.last_run !== want.last_run) begin
          report_mismatch("last_run", run_ch.last_run, want.last_run);
        end
        if (run_ch.raw_byte !== want.raw_byte) begin
          report_mismatch("raw_byte", run_ch.raw_byte, want.raw_byte);
        end
        if (run_ch.checksum !== want.checksum) begin
          report_mismatch("checksum", run_ch.checksum, want.checksum);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    run_ch.ready = 1'b0;
    stall_left   = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        run_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        run_ch.ready <= 1'b1;
        if (!steady_flow && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((item_ch.valid && item_ch.ready) || (run_ch.valid && run_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    int p;
    int i;
    rst_n               = 1'b0;
    item_ch.valid       = 1'b0;
    item_ch.data_byte   = 8'h00;
    item_ch.restart_sum = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_HIGH_LEVEL;
    cfg_ch.data         = 8'h00;
    steady_flow         = 1'b0;
    mismatches          = 0;
    bytes_sent          = 0;
    restarts_sent       = 0;
    runs_checked        = 0;
    zero_runs           = 0;
    reg_writes          = 0;
    unused_writes       = 0;
    idle_cycles         = 0;
    running_sum         = 8'h00;
    run_cfg = '{HIGH_LEVEL_RST, LOW_LEVEL_RST, SHORT_RUN_RST, LONG_RUN_RST, CHECKSUM_SEED_RST};

    // reset settings, seed 0: the first ten sums follow by hand, the last two are computed
    directed_rows = '{
      '{8'h00, 1'b0, 1'b1, 8'h00},
      '{8'hff, 1'b0, 1'b1, 8'hff},
      '{8'h01, 1'b0, 1'b1, 8'h00},
      '{8'h80, 1'b1, 1'b1, 8'h80},
      '{8'h7f, 1'b0, 1'b1, 8'hff},
      '{8'h55, 1'b1, 1'b1, 8'h55},
      '{8'haa, 1'b0, 1'b1, 8'hff},
      '{8'hff, 1'b1, 1'b1, 8'hff},
      '{8'hff, 1'b0, 1'b1, 8'hfe},
      '{8'h01, 1'b0, 1'b1, 8'hff},
      '{8'h3c, 1'b0, 1'b0, 8'h00},
      '{8'hc3, 1'b1, 1'b0, 8'h00}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unused indices must leave the reset settings alone
    write_reg(REG_UNUSED_FIRST, 8'h5a);
    write_reg(REG_UNUSED_LAST, 8'ha5);
    cfg_ch.valid <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_byte(directed_rows[i]);
    end
    drain_runs();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      steady_flow = (p % 4 == 3);
      case (p)
        0: set_config(8'h00, 8'hff, 8'd1, 8'd255, 8'hff);
        1: set_config(8'hff, 8'hff, 8'd0, 8'd0, 8'h00);
        2: set_config(8'h80, 8'h7f, 8'd255, 8'd1, 8'h80);
        3: set_config(8'h00, 8'h00, 8'd255, 8'd255, 8'h01);
        default: begin
          set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        end
      endcase
      run_phase(BYTES_PER_PHASE);
    end
    steady_flow = 1'b0;

    $display("covered %0d bytes (%0d with checksum restart), %0d run beats checked",
             bytes_sent, restarts_sent, runs_checked);
    $display("%0d register writes (%0d to unused indices), %0d zero-length runs, %0d mismatches",
             reg_writes, unused_writes, zero_runs, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
